@@ design/sbse_pkg.sv @@
`default_nettype none

package sbse_pkg;

   // Sizing
   localparam int MAX_BITS    = 64;
   localparam int DELAY_WIDTH = 8;
   localparam int DATA_W      = 64;
   localparam int COUNT_W     = 7;
   localparam int CSR_DATA_W  = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CNT_W       = $clog2(MAX_BITS + 1);
   localparam int IDX_W       = $clog2(MAX_BITS);
   localparam int CMDQ_DEPTH  = 2;
   localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
   localparam int RSPQ_DEPTH  = 2;
   localparam int RSPQ_PTR_W  = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W  = $clog2(RSPQ_DEPTH + 1);

   // Transaction kinds
   localparam logic [1:0] KIND_SHIFT_OUT = 2'd0;
   localparam logic [1:0] KIND_SHIFT_IN  = 2'd1;
   localparam logic [1:0] KIND_TICK      = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BUSY      = 2'd1;
   localparam logic [1:0] ST_BAD_COUNT = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_DELAY  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_DELAY   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_MODE = 2'd2;

   typedef enum logic [1:0] {
      OP_SHIFT_OUT,
      OP_SHIFT_IN,
      OP_TICK,
      OP_IGNORE
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_READY,
      PH_HIGH,
      PH_LOW,
      PH_TAIL
   } phase_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [DATA_W-1:0]  out_bits;
      logic [COUNT_W-1:0] bit_count;
      logic               data_in;
   } req_type;

   typedef struct packed {
      logic              clock_level;
      logic              data_level;
      logic              data_drive;
      logic              busy_res;
      logic              done_res;
      logic [DATA_W-1:0] read_bits;
      logic [1:0]        status;
   } rsp_type;

   // Classified command as it sits in the queue
   typedef struct packed {
      op_type             op;
      logic               count_ok;
      logic [DATA_W-1:0]  out_bits;
      logic [CNT_W-1:0]   bit_count;
      logic               data_in;
   } cmd_type;

   // Queue handshake between the front and the command queue
   typedef struct packed {
      logic push;
      logic full;
   } qin_type;

endpackage

`default_nettype wire

@@ design/sbse_front.sv @@
`default_nettype none

module sbse_front
   import sbse_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  wire      req_push,
   input  req_type  req_payload,
   output logic     req_full,
   input  wire      q_full,
   output qin_type  q_ctl,
   output cmd_type  q_item
);

   logic count_ok;

   // Check the count against the supported range
   assign count_ok = (req_payload.bit_count != '0) &&
                     (req_payload.bit_count <= COUNT_W'(MAX_BITS));

   // Decode the transaction kind
   always_comb begin
      q_item.count_ok = count_ok;
      q_item.out_bits = req_payload.out_bits;
      q_item.bit_count = req_payload.bit_count[CNT_W-1:0];
      q_item.data_in = req_payload.data_in;
      case (req_payload.kind)
         KIND_SHIFT_OUT: q_item.op = OP_SHIFT_OUT;
         KIND_SHIFT_IN:  q_item.op = OP_SHIFT_IN;
         KIND_TICK:      q_item.op = OP_TICK;
         default:        q_item.op = OP_IGNORE;
      endcase
   end

   // Forward accepted transactions to the queue
   assign q_ctl.full = q_full;
   assign q_ctl.push = req_push && !q_full && !reset;
   assign req_full   = q_full;

   logic unused_clock;
   assign unused_clock = clock;

endmodule

`default_nettype wire

@@ design/sbse_cmd_queue.sv @@
`default_nettype none

module sbse_cmd_queue
   import sbse_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  qin_type  q_ctl,
   input  cmd_type  item_in,
   output logic     full,
   input  wire      pop,
   output cmd_type  item_out,
   output logic     empty
);

   cmd_type                slot_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]  count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = q_ctl.push;
   assign do_pop   = pop && !empty;
   assign item_out = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

`default_nettype wire

@@ design/sbse_back.sv @@
`default_nettype none

module sbse_back
   import sbse_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_write_en,
   input  wire [CSR_INDEX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_data,
   input  cmd_type                cmd,
   input  wire                    cmd_empty,
   output logic                   cmd_pop,
   output logic                   rsp_empty,
   input  wire                    rsp_pop,
   output rsp_type                rsp_payload
);

   // Configuration
   logic [DELAY_WIDTH-1:0] high_delay_ff;
   logic [DELAY_WIDTH-1:0] low_delay_ff;
   logic                   sample_before_ff;

   // Sequencer state
   phase_type              phase_ff, phase_in;
   logic [CNT_W-1:0]       remaining_ff, remaining_in;
   logic [MAX_BITS-1:0]    send_ff, send_in;
   logic [MAX_BITS-1:0]    recv_ff, recv_in;
   logic [CNT_W-1:0]       pos_ff, pos_in;
   logic [DELAY_WIDTH-1:0] delay_ff, delay_in;
   logic                   receiving_ff, receiving_in;
   logic                   drive_ff, drive_in;
   logic                   early_ff, early_in;

   // Result queue
   rsp_type                rslot_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0]  rwr_ptr_ff, rwr_ptr_in;
   logic [RSPQ_PTR_W-1:0]  rrd_ptr_ff, rrd_ptr_in;
   logic [RSPQ_CNT_W-1:0]  rcount_ff, rcount_in;

   logic                   step;
   logic                   tick;
   logic                   load;
   logic                   bit_end;
   logic [CNT_W-1:0]       rem_dec;
   logic                   store_en;
   logic [CNT_W-1:0]       store_pos;
   logic                   done;
   logic [1:0]             status;
   rsp_type                result;
   logic                   rsp_take;

   // Take one command whenever the result queue has room
   assign step     = !cmd_empty && (rcount_ff != RSPQ_CNT_W'(RSPQ_DEPTH));
   assign cmd_pop  = step;
   assign tick     = step && (cmd.op == OP_TICK);
   assign load     = step && (cmd.op == OP_SHIFT_OUT || cmd.op == OP_SHIFT_IN) &&
                     (phase_ff == PH_IDLE) && cmd.count_ok;
   assign rem_dec  = remaining_ff - 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         high_delay_ff    <= '0;
         low_delay_ff     <= '0;
         sample_before_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_HIGH_DELAY:  high_delay_ff    <= DELAY_WIDTH'(csr_data);
            CSR_LOW_DELAY:   low_delay_ff     <= DELAY_WIDTH'(csr_data);
            CSR_SAMPLE_MODE: sample_before_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      bit_end  = 1'b0;
      if (load) begin
         phase_in = PH_READY;
      end else if (tick) begin
         case (phase_ff)
            PH_READY: phase_in = PH_HIGH;
            PH_HIGH: begin
               if (delay_ff == '0) begin
                  phase_in = PH_LOW;
                  bit_end  = (low_delay_ff == '0);
               end
            end
            PH_LOW:  bit_end  = (delay_ff <= DELAY_WIDTH'(1));
            PH_TAIL: phase_in = PH_IDLE;
            default: ;
         endcase
         if (bit_end) begin
            if (rem_dec != '0) begin
               phase_in = PH_READY;
            end else if (receiving_ff && !early_ff) begin
               phase_in = PH_TAIL;
            end else begin
               phase_in = PH_IDLE;
            end
         end
      end
   end

   // Datapath and result
   always_comb begin
      remaining_in = remaining_ff;
      send_in      = send_ff;
      recv_in      = recv_ff;
      pos_in       = pos_ff;
      delay_in     = delay_ff;
      receiving_in = receiving_ff;
      drive_in     = drive_ff;
      early_in     = early_ff;
      store_en     = 1'b0;
      store_pos    = pos_ff - 1'b1;
      done         = 1'b0;
      status       = ST_OK;

      if (step && (cmd.op == OP_SHIFT_OUT || cmd.op == OP_SHIFT_IN)) begin
         if (phase_ff != PH_IDLE) begin
            status = ST_BUSY;
         end else if (!cmd.count_ok) begin
            status = ST_BAD_COUNT;
         end
      end

      if (load) begin
         remaining_in = cmd.bit_count;
         pos_in       = '0;
         delay_in     = '0;
         recv_in      = '0;
         early_in     = sample_before_ff;
         receiving_in = (cmd.op == OP_SHIFT_IN);
         drive_in     = (cmd.op == OP_SHIFT_OUT);
         if (cmd.op == OP_SHIFT_OUT) begin
            send_in = cmd.out_bits[MAX_BITS-1:0];
         end
      end else if (tick) begin
         case (phase_ff)
            PH_READY: begin
               delay_in = high_delay_ff;
               if (receiving_ff) begin
                  store_en = early_ff || (pos_ff != '0);
                  if (early_ff) begin
                     store_pos = pos_ff;
                  end
               end
            end
            PH_HIGH: begin
               delay_in = (delay_ff != '0) ? delay_ff - 1'b1 : low_delay_ff;
            end
            PH_LOW: begin
               if (delay_ff != '0) begin
                  delay_in = delay_ff - 1'b1;
               end
            end
            PH_TAIL: begin
               store_en = (pos_ff != '0);
               done     = 1'b1;
            end
            default: ;
         endcase

         // Capture the sampled data bit
         if (store_en && (store_pos < CNT_W'(MAX_BITS)) && cmd.data_in) begin
            recv_in[store_pos[IDX_W-1:0]] = 1'b1;
         end

         // Close out the current bit
         if (bit_end) begin
            pos_in       = pos_ff + 1'b1;
            remaining_in = rem_dec;
            if (rem_dec != '0) begin
               if (!receiving_ff) begin
                  send_in = send_ff >> 1;
               end
            end else if (!(receiving_ff && !early_ff)) begin
               done = 1'b1;
            end
         end
      end

      result.clock_level = (phase_in == PH_HIGH);
      result.data_level  = drive_in && send_in[0];
      result.data_drive  = drive_in;
      result.busy_res    = (phase_in != PH_IDLE);
      result.done_res    = done;
      result.read_bits   = (done && receiving_in) ? DATA_W'(recv_in) : '0;
      result.status      = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         remaining_ff <= '0;
         send_ff      <= '0;
         recv_ff      <= '0;
         pos_ff       <= '0;
         delay_ff     <= '0;
         receiving_ff <= 1'b0;
         drive_ff     <= 1'b0;
         early_ff     <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         send_ff      <= send_in;
         recv_ff      <= recv_in;
         pos_ff       <= pos_in;
         delay_ff     <= delay_in;
         receiving_ff <= receiving_in;
         drive_ff     <= drive_in;
         early_ff     <= early_in;
      end
   end

   // Result queue bookkeeping
   assign rsp_empty   = (rcount_ff == '0);
   assign rsp_take    = rsp_pop && !rsp_empty;
   assign rsp_payload = rslot_ff[rrd_ptr_ff];

   always_comb begin
      rwr_ptr_in = rwr_ptr_ff;
      rrd_ptr_in = rrd_ptr_ff;
      rcount_in  = rcount_ff;
      if (step) begin
         rwr_ptr_in = (rwr_ptr_ff == RSPQ_PTR_W'(RSPQ_DEPTH - 1)) ? '0 : rwr_ptr_ff + 1'b1;
      end
      if (rsp_take) begin
         rrd_ptr_in = (rrd_ptr_ff == RSPQ_PTR_W'(RSPQ_DEPTH - 1)) ? '0 : rrd_ptr_ff + 1'b1;
      end
      if (step && !rsp_take) begin
         rcount_in = rcount_ff + 1'b1;
      end else if (!step && rsp_take) begin
         rcount_in = rcount_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rwr_ptr_ff <= '0;
         rrd_ptr_ff <= '0;
         rcount_ff  <= '0;
      end else begin
         rwr_ptr_ff <= rwr_ptr_in;
         rrd_ptr_ff <= rrd_ptr_in;
         rcount_ff  <= rcount_in;
      end
   end

   // Hold finished results
   always_ff @(posedge clock) begin
      if (step) begin
         rslot_ff[rwr_ptr_ff] <= result;
      end
   end

endmodule

`default_nettype wire

@@ design/serial_bit_shift_engine.sv @@
`default_nettype none

// Synchronous serial shifter, least significant bit first. Push a shift-out
// or shift-in command (1 to 64 bits), then push one tick transaction per
// timing step; each tick carries the sampled data-in pin level and returns
// one result with the clock and data pin levels, busy/done flags, the
// received word on the done tick of a shift-in, and a status (command while
// busy, or bad count, is rejected). The block takes one transaction per
// cycle sustained: the front classifies it into a two-entry command queue,
// the back updates the sequencer and writes the result into a two-entry
// result queue, so a result reaches the result ports once its transaction
// has passed through the command queue and the result queue. The input
// stalls only when results are left waiting and both queues fill. Write the timing and
// sample mode registers only while no transfer is in progress and all
// results have been popped.
module serial_bit_shift_engine
   import sbse_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_push,
   input  req_type                req_payload,
   output logic                   req_full,
   output logic                   rsp_empty,
   input  wire                    rsp_pop,
   output rsp_type                rsp_payload,
   input  wire                    csr_write_en,
   input  wire [CSR_INDEX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_data
);

   qin_type q_ctl;
   cmd_type q_item;
   cmd_type cmd;
   logic    q_full;
   logic    cmd_empty;
   logic    cmd_pop;

   sbse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_payload (req_payload),
      .req_full    (req_full),
      .q_full      (q_full),
      .q_ctl       (q_ctl),
      .q_item      (q_item)
   );

   sbse_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .q_ctl    (q_ctl),
      .item_in  (q_item),
      .full     (q_full),
      .pop      (cmd_pop),
      .item_out (cmd),
      .empty    (cmd_empty)
   );

   sbse_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .cmd_empty    (cmd_empty),
      .cmd_pop      (cmd_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_payload  (rsp_payload)
   );

endmodule

`default_nettype wire

@@ design/sbse_checker.sv @@
`default_nettype none

module sbse_checker
   import sbse_pkg::*;
(
   input wire                    clock,
   input wire                    reset,
   input wire                    req_push,
   input req_type                req_payload,
   input wire                    req_full,
   input wire                    rsp_empty,
   input wire                    rsp_pop,
   input rsp_type                rsp_payload,
   input wire                    csr_write_en,
   input wire [CSR_INDEX_W-1:0]  csr_index,
   input wire [CSR_DATA_W-1:0]   csr_data
);

   // No result survives reset
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // A waiting result holds until popped
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_payload)))
      else $error("waiting result changed");

   // A rejected command never finishes a transfer
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_payload.status != ST_OK) |-> !rsp_payload.done_res)
      else $error("done on rejected command");

   // Finishing leaves the sequencer idle with the clock low
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_payload.done_res) |->
         (!rsp_payload.busy_res && !rsp_payload.clock_level))
      else $error("done while still busy");

   // Received data only shows up on the done result
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_payload.read_bits != '0) |-> rsp_payload.done_res)
      else $error("read data without done");

endmodule

bind serial_bit_shift_engine sbse_checker u_checker (.*);

`default_nettype wire
